// ===== src/svb_pkg.sv =====
// Shared types and constants for the shadow volume builder.
// No dependencies.
package svb_pkg;

    localparam int FIELD_BITS = 12;
    localparam int COUNT_BITS = 16;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_TRI   = 2'd1,
        FUNC_EDGE  = 2'd2,
        FUNC_BEGIN = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_LIGHT_X = 2'd0,
        CFG_LIGHT_Y = 2'd1,
        CFG_LIGHT_Z = 2'd2
    } t_cfg_idx;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

endpackage

// ===== src/svb_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module svb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/shadow_volume_builder.sv =====
// Shadow volume builder top level: sequencer around one shared signed multiplier.
// Depends on svb_pkg and svb_ram. Load and begin items finish on acceptance; busy stays low.
// Edge: read states RD0..RD3, a decide state, then emit, skipped when it is not a silhouette.
// Triangle: read states, 12 multiply steps (cross, then dot), decide, then emit, skipped
// when it faces away. Results are registered, one per cycle, the last as busy drops.
// Results cannot stall. Synchronous active-low reset clears sequencer, counter, light regs.
module shadow_volume_builder #(
    parameter int VERTEX_DEPTH   = 4096,
    parameter int TRIANGLE_DEPTH = 4096,
    parameter int COORD_BITS     = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_func,
    input  logic [svb_pkg::FIELD_BITS-1:0]     i_slot,
    input  logic signed [COORD_BITS-1:0]       i_pos_x,
    input  logic signed [COORD_BITS-1:0]       i_pos_y,
    input  logic signed [COORD_BITS-1:0]       i_pos_z,
    input  logic [svb_pkg::FIELD_BITS-1:0]     i_vert_a,
    input  logic [svb_pkg::FIELD_BITS-1:0]     i_vert_b,
    input  logic [svb_pkg::FIELD_BITS-1:0]     i_vert_c,
    input  logic [svb_pkg::FIELD_BITS-1:0]     i_tri_a,
    input  logic [svb_pkg::FIELD_BITS-1:0]     i_tri_b,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [COORD_BITS-1:0]              i_cfg_data,
    output logic                               o_strobe,
    output logic                               o_kind,
    output logic signed [COORD_BITS+1:0]       o_out_x,
    output logic signed [COORD_BITS+1:0]       o_out_y,
    output logic signed [COORD_BITS+1:0]       o_out_z,
    output logic [svb_pkg::COUNT_BITS-1:0]     o_index_value,
    output logic                               o_last
);
    import svb_pkg::*;

    localparam int VA_BITS = $clog2(VERTEX_DEPTH);
    localparam int TA_BITS = $clog2(TRIANGLE_DEPTH);
    localparam int CB      = COORD_BITS;
    localparam int OB      = COORD_BITS + 2;
    localparam int DB      = COORD_BITS + 1;      // edge difference
    localparam int CRB     = 2 * DB + 1;          // cross component
    localparam int MB      = DB + 1;              // multiplier operand
    localparam int PW      = 2 * MB;              // multiplier product
    localparam int AB      = CRB + CB + 2;        // dot accumulator
    localparam int VW      = 3 * CB;
    localparam logic signed [CB-1:0] ZC = '0;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD0   = 9'b000000010,
        S_RD1   = 9'b000000100,
        S_RD2   = 9'b000001000,
        S_RD3   = 9'b000010000,
        S_CROSS = 9'b000100000,
        S_DOT   = 9'b001000000,
        S_DEC   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic signed [CB-1:0] r_light [3];
    logic [COUNT_BITS-1:0] r_count;

    // latched item
    t_func                 r_func;
    logic [FIELD_BITS-1:0] r_slot, r_va, r_vb, r_vc, r_ta, r_tb;

    logic signed [CB-1:0]  r_p [3][3];
    logic                  r_pv [3];        // vertex address in range
    logic                  r_fa, r_fb;
    logic signed [DB-1:0]  r_d1 [3], r_d2 [3];
    logic signed [CRB-1:0] r_cr [3];
    logic signed [AB-1:0]  r_acc;
    logic [3:0]            r_step;
    logic [3:0]            r_cnt;

    // shared multiplier: operands from the step mux, product registered
    logic signed [PW-1:0]  r_prod;
    logic                  r_mphase;

    // vertex RAM
    logic               ram_we;
    logic [VA_BITS-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0]      ram_wdata, ram_rdata;
    logic [FIELD_BITS-1:0] rd_sel;

    // facing RAM
    logic               fac_we, fac_wdata, fac_rdata;
    logic [TA_BITS-1:0] fac_waddr, fac_raddr;
    logic [FIELD_BITS-1:0] fac_sel;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    function automatic logic in_vrange(input logic [FIELD_BITS-1:0] a);
        return 32'(a) < VERTEX_DEPTH;
    endfunction
    function automatic logic in_trange(input logic [FIELD_BITS-1:0] a);
        return 32'(a) < TRIANGLE_DEPTH;
    endfunction

    assign ram_we    = accept && (t_func'(i_func) == FUNC_LOAD) && in_vrange(i_slot);
    assign ram_waddr = VA_BITS'(i_slot);
    assign ram_wdata = {i_pos_z, i_pos_y, i_pos_x};

    always_comb begin
        case (r_state)
            S_RD0:   rd_sel = r_vb;
            S_RD1:   rd_sel = r_vc;
            default: rd_sel = r_va;
        endcase
    end
    assign ram_raddr = accept ? VA_BITS'(i_vert_a) : VA_BITS'(rd_sel);

    svb_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH)) u_vram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic face_now;
    assign face_now  = !r_acc[AB-1];
    assign fac_we    = (r_state == S_DEC) && (r_func == FUNC_TRI) && in_trange(r_slot);
    assign fac_waddr = TA_BITS'(r_slot);
    assign fac_wdata = face_now;
    assign fac_sel   = accept ? i_tri_a : r_tb;
    assign fac_raddr = TA_BITS'(fac_sel);

    svb_ram #(.WIDTH(1), .DEPTH(TRIANGLE_DEPTH)) u_fram (
        .i_clk  (i_clk),
        .i_we   (fac_we),
        .i_waddr(fac_waddr),
        .i_wdata(fac_wdata),
        .i_raddr(fac_raddr),
        .o_rdata(fac_rdata)
    );

    // multiply schedule: steps 0..5 cross terms, 6..11 dot terms with each
    // cross component split into an unsigned low half and a signed high half
    logic signed [MB-1:0] op_a;
    logic signed [MB-1:0] op_b;
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_step)
            4'd0:  begin op_a = MB'(r_d1[1]); op_b = MB'(r_d2[2]); end
            4'd1:  begin op_a = MB'(r_d1[2]); op_b = MB'(r_d2[1]); end
            4'd2:  begin op_a = MB'(r_d1[2]); op_b = MB'(r_d2[0]); end
            4'd3:  begin op_a = MB'(r_d1[0]); op_b = MB'(r_d2[2]); end
            4'd4:  begin op_a = MB'(r_d1[0]); op_b = MB'(r_d2[1]); end
            4'd5:  begin op_a = MB'(r_d1[1]); op_b = MB'(r_d2[0]); end
            4'd6:  begin op_a = $signed({1'b0, r_cr[0][DB-1:0]}); op_b = MB'(r_light[0]); end
            4'd7:  begin op_a = r_cr[0][CRB-1:DB];                op_b = MB'(r_light[0]); end
            4'd8:  begin op_a = $signed({1'b0, r_cr[1][DB-1:0]}); op_b = MB'(r_light[1]); end
            4'd9:  begin op_a = r_cr[1][CRB-1:DB];                op_b = MB'(r_light[1]); end
            4'd10: begin op_a = $signed({1'b0, r_cr[2][DB-1:0]}); op_b = MB'(r_light[2]); end
            4'd11: begin op_a = r_cr[2][CRB-1:DB];                op_b = MB'(r_light[2]); end
            default: ;
        endcase
    end

    // output vertex selection
    logic signed [OB-1:0] ext [3];
    logic                 is_tri;
    logic [1:0]           vsel;
    logic                 vext;
    logic [COUNT_BITS-1:0] ioff;
    assign is_tri = (r_func == FUNC_TRI);
    always_comb begin
        vsel = 2'd0;
        vext = 1'b0;
        ioff = '0;
        if (is_tri) begin
            vsel = (r_cnt < 4'd3) ? r_cnt[1:0] : 2'(r_cnt - 4'd3);
            vext = (r_cnt >= 4'd3);
            case (r_cnt)
                4'd6:  ioff = 16'd2;
                4'd7:  ioff = 16'd1;
                4'd8:  ioff = 16'd0;
                4'd9:  ioff = 16'd3;
                4'd10: ioff = 16'd4;
                4'd11: ioff = 16'd5;
                default: ioff = COUNT_BITS'(r_cnt);
            endcase
        end else begin
            vsel = {1'b0, r_cnt[0]};
            vext = r_cnt[1];
            case (r_cnt)
                4'd4:  ioff = 16'd1;
                4'd5:  ioff = 16'd2;
                4'd6:  ioff = 16'd0;
                4'd7:  ioff = 16'd1;
                4'd8:  ioff = 16'd3;
                4'd9:  ioff = 16'd2;
                default: ioff = COUNT_BITS'(r_cnt);
            endcase
        end
    end
    for (genvar g = 0; g < 3; g++) begin : g_ext
        assign ext[g] = (OB'(r_p[vsel][g]) <<< 1) - OB'(r_light[g]);
    end

    logic [3:0] n_total;
    assign n_total = is_tri ? 4'd12 : 4'd10;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_func'(i_func) == FUNC_TRI || t_func'(i_func) == FUNC_EDGE) begin
                        n_state = S_RD0;
                    end
                end
            end
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = is_tri ? S_CROSS : S_DEC;
            S_CROSS: if (r_mphase && r_step == 4'd5) n_state = S_DOT;
            S_DOT:   if (r_mphase && r_step == 4'd11) n_state = S_DEC;
            S_DEC: begin
                if (is_tri) n_state = face_now ? S_EMIT : S_IDLE;
                else        n_state = (r_fa != r_fb) ? S_EMIT : S_IDLE;
            end
            S_EMIT:  if (r_cnt == n_total - 4'd1) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_light[0] <= '0;
            r_light[1] <= '0;
            r_light[2] <= '0;
            o_strobe <= 1'b0;
            o_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == S_EMIT);
            o_last   <= (r_state == S_EMIT) && (r_cnt == n_total - 4'd1);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LIGHT_X: r_light[0] <= i_cfg_data;
                    CFG_LIGHT_Y: r_light[1] <= i_cfg_data;
                    CFG_LIGHT_Z: r_light[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && t_func'(i_func) == FUNC_BEGIN) begin
                r_count <= '0;
            end
            if (r_state == S_EMIT && r_cnt == n_total - 4'd1) begin
                r_count <= r_count + (is_tri ? 16'd6 : 16'd4);
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_func);
            r_slot <= i_slot;
            r_va <= i_vert_a; r_vb <= i_vert_b; r_vc <= i_vert_c;
            r_ta <= i_tri_a;  r_tb <= i_tri_b;
            r_step <= '0;
            r_mphase <= 1'b0;
            r_cnt <= '0;
            r_acc <= '0;
        end
        // RAM data of the read issued in the previous cycle
        case (r_state)
            S_RD0: begin
                r_p[0] <= '{ram_rdata[CB-1:0], ram_rdata[2*CB-1:CB], ram_rdata[VW-1:2*CB]};
                r_pv[0] <= in_vrange(r_va);
                r_fa <= fac_rdata && in_trange(r_ta);
            end
            S_RD1: begin
                r_p[1] <= '{ram_rdata[CB-1:0], ram_rdata[2*CB-1:CB], ram_rdata[VW-1:2*CB]};
                r_pv[1] <= in_vrange(r_vb);
                r_fb <= fac_rdata && in_trange(r_tb);
            end
            S_RD2: begin
                r_p[2] <= '{ram_rdata[CB-1:0], ram_rdata[2*CB-1:CB], ram_rdata[VW-1:2*CB]};
                r_pv[2] <= in_vrange(r_vc);
            end
            S_RD3: begin
                // clear out-of-range vertices, form edge differences
                for (int i = 0; i < 3; i++) begin
                    if (!r_pv[i]) r_p[i] <= '{default: '0};
                end
                for (int j = 0; j < 3; j++) begin
                    r_d1[j] <= DB'(r_pv[1] ? r_p[1][j] : ZC) - DB'(r_pv[0] ? r_p[0][j] : ZC);
                    r_d2[j] <= DB'(r_pv[2] ? r_p[2][j] : ZC) - DB'(r_pv[0] ? r_p[0][j] : ZC);
                end
            end
            S_CROSS, S_DOT: begin
                // phase 0 forms the product, phase 1 consumes it
                if (r_mphase) begin
                    if (r_state == S_CROSS) begin
                        if (!r_step[0]) r_cr[r_step[2:1]] <= CRB'(r_prod);
                        else            r_cr[r_step[2:1]] <= r_cr[r_step[2:1]] - CRB'(r_prod);
                    end else begin
                        if (!r_step[0]) r_acc <= r_acc + AB'(r_prod);
                        else            r_acc <= r_acc + (AB'(r_prod) <<< DB);
                    end
                    r_step <= r_step + 4'd1;
                end
                r_mphase <= !r_mphase;
            end
            S_EMIT: r_cnt <= r_cnt + 4'd1;
            default: ;
        endcase
        r_prod <= PW'(op_a) * PW'(op_b);

        o_kind        <= (r_cnt >= (is_tri ? 4'd6 : 4'd4)) ? KIND_INDEX : KIND_VERTEX;
        o_index_value <= r_count + ioff;
        if (r_cnt >= (is_tri ? 4'd6 : 4'd4)) begin
            o_out_x <= '0; o_out_y <= '0; o_out_z <= '0;
        end else if (vext) begin
            o_out_x <= ext[0]; o_out_y <= ext[1]; o_out_z <= ext[2];
        end else begin
            o_out_x <= OB'(r_p[vsel][0]);
            o_out_y <= OB'(r_p[vsel][1]);
            o_out_z <= OB'(r_p[vsel][2]);
        end
    end

    ap_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe) else $error("last without strobe");
    ap_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> !o_strobe || o_last || $past(o_strobe)) else
        $error("strobe from idle");
    ap_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> busy) else $error("emit while not busy");
endmodule
